// ----- rtl/trn_pkg.sv -----
package trn_pkg;

  localparam int TotalW = 63;
  localparam int LocalW = 31;
  localparam int TickW  = 32;
  localparam int NumChW = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam logic [TotalW-1:0] TOTAL_MAX = {TotalW{1'b1}};
  localparam logic [TickW-1:0]  TICK_MAX  = {TickW{1'b1}};

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_REPLY = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_HAS_PARENT   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_NUM_CHILDREN = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_INTERVAL     = 2'd2;

  localparam logic [TickW-1:0] INTERVAL_RST = 32'd1000;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_PARTIAL = 3'd2,
    ACT_INVALID = 3'd3,
    ACT_FINAL   = 3'd4
  } action_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic              cleanup;
    logic [LocalW-1:0] local_count;
    logic              child_valid;
    logic [TotalW-1:0] child_total;
  } in_item_t;

  typedef struct packed {
    action_t           action;
    logic              result_valid;
    logic [TotalW-1:0] result_total;
    logic              busy_res;
  } out_item_t;

endpackage

// ----- rtl/tree_reduce_node.sv -----
// One node of a periodic tree sum reduction.
// Input channel (in_valid/in_ready/in_data): one item per poll tick, child
// reply or parent start request; each item carries the local count and the
// cleanup flag. Result channel (out_valid/out_ready/out_data): exactly one
// item per input item, in order, giving the action taken, the reported
// total and whether a reduction is still outstanding.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always
// ready; index 0 has_parent, 1 num_children, 2 interval_ticks. Write only
// while no item is in flight.
// Result path: an accepted item waits in the input register until the result
// register can take it, then moves into the result register, which the node
// state updates along with.
// Throughput: one item per cycle while out_ready stays high; the combinational
// state update with one 3-operand 65-bit saturating add sets the clock limit.
// Reset (rst_n low, synchronous): both stages empty, node state and
// registers return to their defaults (has_parent 1, num_children 0,
// interval 1000 ticks, total valid).
// Receiver stall: the result register holds; the input register fills and
// in_ready drops until out_ready returns, so no item is lost.
module tree_reduce_node #(
  parameter int MAX_KIDS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  trn_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output trn_pkg::out_item_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [trn_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [trn_pkg::CfgDataW-1:0] cfg_data
);
  import trn_pkg::*;

  localparam int CntBits = $clog2(MAX_KIDS + 1);
  localparam int CntW = (CntBits > NumChW) ? NumChW : CntBits;

  in_item_t          in_r;
  logic              in_vld_r;
  out_item_t         out_r, out_nxt;
  logic              out_vld_r;
  logic              fire;

  logic              has_parent_r;
  logic [NumChW-1:0] num_children_r;
  logic [TickW-1:0]  interval_r;

  logic              outst_r, outst_nxt;
  logic [CntW-1:0]   rcnt_r, rcnt_nxt;
  logic              sv_r, sv_nxt;
  logic [TotalW-1:0] total_r, total_nxt;
  logic [TickW-1:0]  ticks_r, ticks_nxt;
  logic              pend_r, pend_nxt;

  logic [CntW-1:0]   lim;
  logic [TickW-1:0]  ticks_inc;
  logic              pend_set;
  logic              take_reply;
  logic [CntW-1:0]   rcnt_upd;
  logic              done;
  logic [TotalW-1:0] add_b;
  logic [LocalW-1:0] add_c;
  logic [TotalW+1:0] sum3;
  logic [TotalW-1:0] sum_sat;
  logic              expired;
  logic              start;

  assign fire      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || fire;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign lim = (int'(num_children_r) > MAX_KIDS) ? CntW'(MAX_KIDS)
                                                 : CntW'(num_children_r);

  always_comb begin
    ticks_inc  = (in_r.operation == OP_TICK && ticks_r != TICK_MAX) ? ticks_r + 1'b1
                                                                   : ticks_r;
    pend_set   = pend_r || (in_r.operation == OP_START && has_parent_r);
    take_reply = outst_r && in_r.operation == OP_REPLY && rcnt_r < lim;
    rcnt_upd   = take_reply ? rcnt_r + 1'b1 : rcnt_r;
    done       = outst_r && rcnt_upd >= lim;
    add_b      = (take_reply && in_r.child_valid) ? in_r.child_total : '0;
    add_c      = done ? in_r.local_count : '0;
    sum3       = {2'b00, total_r} + {2'b00, add_b} + (TotalW + 2)'(add_c);
    sum_sat    = (sum3[TotalW+1:TotalW] != 2'b00) ? TOTAL_MAX : sum3[TotalW-1:0];
    expired    = ticks_inc >= interval_r || in_r.cleanup;
    start      = !outst_r && expired && (!has_parent_r || pend_set);
  end

  always_comb begin
    ticks_nxt = ticks_inc;
    pend_nxt  = pend_set;
    outst_nxt = outst_r;
    rcnt_nxt  = rcnt_upd;
    sv_nxt    = sv_r;
    total_nxt = total_r;
    out_nxt   = '{action: ACT_NONE, result_valid: 1'b0, result_total: '0, busy_res: 1'b0};
    if (outst_r) begin
      if (take_reply && !in_r.child_valid) begin
        sv_nxt = 1'b0;
      end
      total_nxt = sum_sat;
      if (done) begin
        outst_nxt = 1'b0;
        if (has_parent_r) begin
          out_nxt.action       = ACT_PARTIAL;
          out_nxt.result_valid = sv_nxt;
          out_nxt.result_total = sum_sat;
        end else if (sv_nxt) begin
          out_nxt.action       = ACT_FINAL;
          out_nxt.result_valid = 1'b1;
          out_nxt.result_total = sum_sat;
        end
      end
    end else begin
      if (expired && has_parent_r && pend_set) begin
        pend_nxt = 1'b0;
      end
      if (start && in_r.cleanup) begin
        sv_nxt = 1'b0;
        if (has_parent_r) begin
          out_nxt.action = ACT_INVALID;
        end
      end else if (start) begin
        ticks_nxt            = '0;
        outst_nxt            = 1'b1;
        rcnt_nxt             = '0;
        sv_nxt               = 1'b1;
        total_nxt            = '0;
        out_nxt.action       = ACT_START;
        out_nxt.result_valid = 1'b1;
      end
    end
    out_nxt.busy_res = outst_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_parent_r   <= 1'b1;
      num_children_r <= '0;
      interval_r     <= INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HAS_PARENT:   has_parent_r   <= cfg_data[0];
        REG_NUM_CHILDREN: num_children_r <= cfg_data[NumChW-1:0];
        REG_INTERVAL:     interval_r     <= cfg_data[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outst_r <= 1'b0;
      rcnt_r  <= '0;
      sv_r    <= 1'b1;
      total_r <= '0;
      ticks_r <= '0;
      pend_r  <= 1'b0;
    end else if (fire) begin
      outst_r <= outst_nxt;
      rcnt_r  <= rcnt_nxt;
      sv_r    <= sv_nxt;
      total_r <= total_nxt;
      ticks_r <= ticks_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

// ----- rtl/trn_checker.sv -----
module trn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input trn_pkg::out_item_t out_data
);
  import trn_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_start_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action == ACT_START |->
      out_data.result_valid && out_data.result_total == '0 && out_data.busy_res)
    else $error("start item malformed");

  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.action == ACT_NONE || out_data.action == ACT_INVALID) |->
      !out_data.result_valid && out_data.result_total == '0)
    else $error("empty report carries data");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.action == ACT_PARTIAL || out_data.action == ACT_FINAL ||
                  out_data.action == ACT_INVALID) |-> !out_data.busy_res)
    else $error("busy after report");

  a_final_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action == ACT_FINAL |-> out_data.result_valid)
    else $error("final result not valid");

endmodule

bind tree_reduce_node trn_checker u_trn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- verif/tree_reduce_node_tb.sv -----
`timescale 1ns / 100ps

module tree_reduce_node_tb;
  import trn_pkg::*;

  localparam int         MAX_CH      = 8;
  localparam int         CYCLE_LIMIT = 400000;
  localparam logic [1:0] OP_NOP      = 2'd3;

  typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_STALLY} rx_mode_t;

  typedef struct {
    in_item_t  item;
    bit        has_exp;
    out_item_t exp;
  } feed_t;

  typedef struct {
    bit                  is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    feed_t               step;
  } dir_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  tree_reduce_node #(.MAX_KIDS(MAX_CH)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // node shadow state and register copies
  logic              cf_has_parent = 1'b1;
  logic [NumChW-1:0] cf_children   = '0;
  logic [TickW-1:0]  cf_interval   = INTERVAL_RST;
  logic              st_busy       = 1'b0;
  logic [NumChW-1:0] st_replies    = '0;
  logic              st_sum_ok     = 1'b1;
  logic [TotalW-1:0] st_total      = '0;
  logic [TickW-1:0]  st_ticks      = '0;
  logic              st_pend       = 1'b0;

  feed_t     item_q[$];
  out_item_t pending_reports[$];
  feed_t     drv_cur;
  bit        in_took  = 1'b0;
  bit        cfg_done = 1'b0;
  int        n_queued = 0;
  int        n_accepted = 0;
  int        n_err = 0;
  int        cyc = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        rdy_left = 0;
  int        mode_left = 0;
  rx_mode_t  rx_mode = RX_FREE;

  function automatic logic [TotalW-1:0] sat_sum(logic [TotalW-1:0] a, logic [TotalW-1:0] b);
    logic [TotalW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TotalW] ? TOTAL_MAX : s[TotalW-1:0];
  endfunction

  function automatic out_item_t predict_report(in_item_t it);
    out_item_t         r;
    logic [NumChW-1:0] lim;
    bit                go;
    r   = '0;
    go  = 1'b0;
    lim = (cf_children > MAX_CH) ? NumChW'(MAX_CH) : cf_children;
    if (it.operation == OP_TICK && st_ticks != TICK_MAX) st_ticks++;
    if (it.operation == OP_START && cf_has_parent) st_pend = 1'b1;
    if (st_busy) begin
      if (it.operation == OP_REPLY && st_replies < lim) begin
        st_replies++;
        if (!it.child_valid) st_sum_ok = 1'b0;
        else st_total = sat_sum(st_total, it.child_total);
      end
      if (st_replies >= lim) begin
        st_total = sat_sum(st_total, {{(TotalW-LocalW){1'b0}}, it.local_count});
        if (cf_has_parent) begin
          r.action       = ACT_PARTIAL;
          r.result_valid = st_sum_ok;
          r.result_total = st_total;
        end else if (st_sum_ok) begin
          r.action       = ACT_FINAL;
          r.result_valid = 1'b1;
          r.result_total = st_total;
        end
        st_busy = 1'b0;
      end
    end else begin
      if (st_ticks >= cf_interval || it.cleanup) begin
        if (!cf_has_parent) begin
          go = 1'b1;
        end else if (st_pend) begin
          st_pend = 1'b0;
          go      = 1'b1;
        end
      end
      if (go && it.cleanup) begin
        go        = 1'b0;
        st_sum_ok = 1'b0;
        if (cf_has_parent) r.action = ACT_INVALID;
      end
      if (go) begin
        st_ticks       = '0;
        st_busy        = 1'b1;
        st_replies     = '0;
        st_sum_ok      = 1'b1;
        st_total       = '0;
        r.action       = ACT_START;
        r.result_valid = 1'b1;
      end
    end
    r.busy_res = st_busy;
    return r;
  endfunction

  // scoreboard, predictor and register shadow
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("unexpected result: action %0d valid %0b total %0h busy %0b",
                     out_data.action, out_data.result_valid, out_data.result_total,
                     out_data.busy_res);
        end else begin
          want = pending_reports.pop_front();
          if (out_data.action !== want.action || out_data.result_valid !== want.result_valid
              || out_data.result_total !== want.result_total
              || out_data.busy_res !== want.busy_res) begin
            n_err++;
            if (n_err <= 10)
              $display({"result mismatch: expected action %0d valid %0b total %0h busy %0b,",
                        " got action %0d valid %0b total %0h busy %0b"},
                       want.action, want.result_valid, want.result_total, want.busy_res,
                       out_data.action, out_data.result_valid, out_data.result_total,
                       out_data.busy_res);
          end
        end
      end
      if (in_valid && in_ready) begin
        want = predict_report(drv_cur.item);
        pending_reports.push_back(drv_cur.has_exp ? drv_cur.exp : want);
        n_accepted++;
        in_took = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HAS_PARENT:   cf_has_parent = cfg_data[0];
          REG_NUM_CHILDREN: cf_children   = cfg_data[NumChW-1:0];
          REG_INTERVAL:     cf_interval   = cfg_data;
          default: ;
        endcase
        cfg_done = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // sender: bursts with gaps
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_took)) begin
      in_took = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (item_q.size() > 0) begin
        drv_cur = item_q.pop_front();
        in_data  <= drv_cur.item;
        in_valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switching between modes
  always @(negedge clk) begin
    logic rdy_next;
    if (rst_n) begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (rdy_left > 0) begin
        rdy_left--;
      end else begin
        rdy_next = (rx_mode == RX_FREE) ? 1'b1 : !out_ready;
        if (rdy_next) rdy_left = $urandom_range(0, 7);
        else rdy_left = (rx_mode == RX_STALLY) ? $urandom_range(2, 24) : $urandom_range(0, 2);
        out_ready <= rdy_next;
      end
    end
  end

  function automatic dir_row_t row_item(logic [1:0] op, logic cln, logic [LocalW-1:0] loc,
                                        logic cv, logic [TotalW-1:0] ct, bit chk,
                                        action_t act, logic rv, logic [TotalW-1:0] rt,
                                        logic busy);
    dir_row_t r;
    r.is_cfg                 = 1'b0;
    r.idx                    = '0;
    r.data                   = '0;
    r.step.item.operation    = op;
    r.step.item.cleanup      = cln;
    r.step.item.local_count  = loc;
    r.step.item.child_valid  = cv;
    r.step.item.child_total  = ct;
    r.step.has_exp           = chk;
    r.step.exp.action        = act;
    r.step.exp.result_valid  = rv;
    r.step.exp.result_total  = rt;
    r.step.exp.busy_res      = busy;
    return r;
  endfunction

  function automatic dir_row_t row_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    dir_row_t r;
    r        = row_item(OP_NOP, 0, 0, 0, 0, 0, ACT_NONE, 0, 0, 0);
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic in_item_t rand_item(logic [1:0] op);
    in_item_t it;
    it.operation   = op;
    it.cleanup     = ($urandom_range(0, 15) == 0);
    it.child_valid = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 7))
      0:       it.local_count = '1;
      1:       it.local_count = '0;
      2:       it.local_count = LocalW'($urandom);
      default: it.local_count = LocalW'($urandom_range(0, 1000));
    endcase
    case ($urandom_range(0, 7))
      0:       it.child_total = TOTAL_MAX;
      1:       it.child_total = TotalW'({$urandom, $urandom});
      2:       it.child_total = '0;
      default: it.child_total = TotalW'($urandom);
    endcase
    return it;
  endfunction

  task automatic push_item(in_item_t it);
    feed_t f;
    f.item    = it;
    f.has_exp = 1'b0;
    f.exp     = '0;
    item_q.push_back(f);
    n_queued++;
  endtask

  // ticks toward the interval, a parent request, the replies, then noise
  task automatic push_round(logic parent, logic [NumChW-1:0] ch, logic [TickW-1:0] iv);
    int k;
    int n;
    k = (iv < 6) ? $urandom_range(0, iv + 1) : $urandom_range(0, 3);
    repeat (k) push_item(rand_item(OP_TICK));
    if (parent || $urandom_range(0, 2) == 0) push_item(rand_item(OP_START));
    n = (ch > MAX_CH) ? MAX_CH : ch;
    if ($urandom_range(0, 4) == 0) n += $urandom_range(1, 2);
    if (n > 0 && $urandom_range(0, 7) == 0) n--;
    repeat (n) push_item(rand_item(OP_REPLY));
    repeat ($urandom_range(0, 2)) push_item(rand_item(2'($urandom_range(0, 3))));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (n_accepted != n_queued || pending_reports.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk);
    while (!cfg_done);
    cfg_done = 1'b0;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    dir_row_t          dir_tbl[$];
    feed_t             f;
    int                ph;
    int                ph_start;
    logic              ph_parent;
    logic [NumChW-1:0] ph_ch;
    logic [TickW-1:0]  ph_iv;

    // defaults: non-root, no children, long interval
    dir_tbl.push_back(row_item(OP_TICK,  0, 0, 0, 0, 1, ACT_NONE, 0, 0, 0));
    dir_tbl.push_back(row_item(OP_REPLY, 0, 0, 1, TOTAL_MAX, 1, ACT_NONE, 0, 0, 0));
    dir_tbl.push_back(row_item(OP_START, 1, 0, 0, 0, 1, ACT_INVALID, 0, 0, 0));
    dir_tbl.push_back(row_item(OP_NOP,   0, 0, 0, 0, 1, ACT_NONE, 0, 0, 0));
    dir_tbl.push_back(row_item(OP_START, 0, 0, 0, 0, 1, ACT_NONE, 0, 0, 0));
    dir_tbl.push_back(row_cfg(REG_INTERVAL, 32'd0));
    dir_tbl.push_back(row_item(OP_TICK,  0, '1, 0, 0, 1, ACT_START, 1, 0, 1));
    dir_tbl.push_back(row_item(OP_REPLY, 0, 7, 1, 5, 1, ACT_PARTIAL, 1, 7, 0));
    dir_tbl.push_back(row_cfg(REG_NUM_CHILDREN, 32'd2));
    dir_tbl.push_back(row_item(OP_START, 0, 0, 0, 0, 1, ACT_START, 1, 0, 1));
    dir_tbl.push_back(row_item(OP_REPLY, 0, 0, 1, TOTAL_MAX, 1, ACT_NONE, 0, 0, 1));
    dir_tbl.push_back(row_item(OP_TICK,  1, 0, 0, 0, 1, ACT_NONE, 0, 0, 1));
    dir_tbl.push_back(row_item(OP_REPLY, 0, 5, 1, 1, 1, ACT_PARTIAL, 1, TOTAL_MAX, 0));
    dir_tbl.push_back(row_item(OP_START, 0, 0, 0, 0, 1, ACT_START, 1, 0, 1));
    dir_tbl.push_back(row_item(OP_REPLY, 0, 0, 0, 123, 1, ACT_NONE, 0, 0, 1));
    dir_tbl.push_back(row_item(OP_REPLY, 0, 3, 1, 10, 1, ACT_PARTIAL, 0, 13, 0));
    dir_tbl.push_back(row_cfg(REG_HAS_PARENT, 32'd0));
    dir_tbl.push_back(row_item(OP_TICK,  0, 0, 0, 0, 1, ACT_START, 1, 0, 1));
    dir_tbl.push_back(row_item(OP_REPLY, 0, 0, 0, 9, 1, ACT_NONE, 0, 0, 1));
    dir_tbl.push_back(row_item(OP_REPLY, 0, 1, 1, 4, 1, ACT_NONE, 0, 0, 0));
    dir_tbl.push_back(row_item(OP_START, 0, 0, 0, 0, 1, ACT_START, 1, 0, 1));
    dir_tbl.push_back(row_item(OP_REPLY, 0, 0, 1, 100, 1, ACT_NONE, 0, 0, 1));
    dir_tbl.push_back(row_item(OP_REPLY, 0, 50, 1, 200, 1, ACT_FINAL, 1, 350, 0));
    dir_tbl.push_back(row_item(OP_TICK,  1, 0, 0, 0, 1, ACT_NONE, 0, 0, 0));
    dir_tbl.push_back(row_cfg(REG_NUM_CHILDREN, 32'd15));
    dir_tbl.push_back(row_cfg(REG_INTERVAL, 32'hFFFF_FFFF));
    dir_tbl.push_back(row_item(OP_TICK,  0, 0, 0, 0, 1, ACT_NONE, 0, 0, 0));
    dir_tbl.push_back(row_cfg(REG_INTERVAL, 32'd1));
    dir_tbl.push_back(row_item(OP_TICK,  0, 9, 1, 0, 0, ACT_NONE, 0, 0, 0));
    dir_tbl.push_back(row_item(OP_REPLY, 0, '1, 1, 'h1234_5678_9ABC, 0, ACT_NONE, 0, 0, 0));
    dir_tbl.push_back(row_item(OP_NOP,   1, 2, 0, 77, 0, ACT_NONE, 0, 0, 0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg) begin
        wait_drained();
        write_reg(dir_tbl[i].idx, dir_tbl[i].data);
      end else begin
        f = dir_tbl[i].step;
        item_q.push_back(f);
        n_queued++;
      end
    end

    for (ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin ph_parent = 1'b0; ph_ch = 4'd0;  ph_iv = 32'd0;          end
        1: begin ph_parent = 1'b1; ph_ch = 4'd15; ph_iv = 32'd1;          end
        2: begin ph_parent = 1'b1; ph_ch = 4'd8;  ph_iv = 32'hFFFF_FFFF;  end
        default: begin
          ph_parent = 1'($urandom_range(0, 1));
          ph_ch     = ($urandom_range(0, 5) == 0) ? NumChW'($urandom_range(9, 15))
                                                  : NumChW'($urandom_range(0, 8));
          ph_iv     = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 5);
        end
      endcase
      wait_drained();
      write_reg(REG_HAS_PARENT, {{(CfgDataW-1){1'b0}}, ph_parent});
      write_reg(REG_NUM_CHILDREN, {{(CfgDataW-NumChW){1'b0}}, ph_ch});
      write_reg(REG_INTERVAL, ph_iv);
      ph_start = n_queued;
      while (n_queued - ph_start < 112) push_round(ph_parent, ph_ch, ph_iv);
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (n_err == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
